### rtl/core/assert_macros.svh
// Assertion helpers: checks are compiled only when SYNTH is not defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/smstep_pkg.sv
package smstep_pkg;

    localparam int DEF_NUM_ROUTINES = 16;
    localparam int DEF_ROUTINE_LEN  = 64;
    localparam int DEF_STACK_DEPTH  = 64;
    localparam int DEF_NUM_VARS     = 16;

    localparam int KIND_W      = 2;
    localparam int ROUTINE_W   = 4;
    localparam int OPCODE_W    = 3;
    localparam int DATA_W      = 32;
    localparam int VAR_W       = 4;
    localparam int OUT_IDX_W   = 7;
    localparam int OUT_SIZE_W  = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 88;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_STEP    = 2'd1,
        KIND_ASSIGN  = 2'd2,
        KIND_RESTART = 2'd3
    } kind_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MUL   = 3'd3,
        OP_WRITE = 3'd4,
        OP_READ  = 3'd5,
        OP_JUMP  = 3'd6,
        OP_JUMPZ = 3'd7
    } opcode_t;

    typedef struct packed {
        logic [ROUTINE_W-1:0]     tgt;
        logic [VAR_W-1:0]         var_idx;
        logic signed [DATA_W-1:0] imm;
        opcode_t                  op;
    } instr_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PREV = 2'd1,
        CELL_NEXT = 2'd2
    } cell_op_t;

    typedef enum logic [2:0] {
        STK_NOP   = 3'd0,
        STK_PUSH  = 3'd1,
        STK_POP   = 3'd2,
        STK_BINOP = 3'd3,
        STK_CLEAR = 3'd4
    } stk_op_t;

    typedef struct packed {
        stk_op_t           op;
        logic [DATA_W-1:0] value;
    } stk_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] second;
        logic              full;
        logic              overflow;
    } stk_stat_t;

endpackage

### rtl/core/stack_machine_step.sv
// Stack-machine interpreter. One input request is one of: load an instruction
// (appended to a routine), execute one step, assign a variable, or restart;
// every request returns one result, registered in ST_DONE. Loads, assignments
// and restarts reach ST_DONE through ST_LOAD, ST_ASSIGN or ST_RESTART; steps
// go through ST_FETCH and, unless the routine is already finished, ST_EXEC,
// followed by ST_MUL_WB for mul or ST_VAR_WB for read. The next request is
// accepted the cycle after the result is registered. The program store's read
// and the multiplier are registered. The value stack is a row of shifting
// cells, top at cell 0. A new request is accepted once the previous result
// sits in the output register, even if it has not been taken yet.
`include "assert_macros.svh"

module stack_machine_step #(
    parameter int NUM_ROUTINES = smstep_pkg::DEF_NUM_ROUTINES,
    parameter int ROUTINE_LEN  = smstep_pkg::DEF_ROUTINE_LEN,
    parameter int STACK_DEPTH  = smstep_pkg::DEF_STACK_DEPTH,
    parameter int NUM_VARS     = smstep_pkg::DEF_NUM_VARS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [smstep_pkg::ROUTINE_W-1:0]    cfg_data,     // start_routine
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // routine_sel[3:0], opcode[6:4], immediate[38:7], var_sel[42:39],
    // jump_target[46:43], zero[47]
    input  logic [smstep_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [smstep_pkg::KIND_W-1:0]       s_axis_tuser, // kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // finished[0], instant[32:1], instruction_index[39:33], routine_now[43:40],
    // stack_top[75:44], stack_size[82:76], stack_overflow[83], load_full[84],
    // zero[87:85]
    output logic [smstep_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import smstep_pkg::*;

    localparam int RW   = (NUM_ROUTINES > 1) ? $clog2(NUM_ROUTINES) : 1;
    localparam int VIW  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int LW   = $clog2(ROUTINE_LEN + 1);
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int PDEP = NUM_ROUTINES * ROUTINE_LEN;
    localparam int PA_W = (PDEP > 1) ? $clog2(PDEP) : 1;
    localparam logic [PA_W-1:0] RL_PA = PA_W'(ROUTINE_LEN);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_FETCH,
        ST_EXEC,
        ST_MUL_WB,
        ST_VAR_WB,
        ST_ASSIGN,
        ST_RESTART,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    kind_t                   kind_reg, kind_next;
    logic [ROUTINE_W-1:0]    rsel_reg, rsel_next;
    opcode_t                 opc_reg, opc_next;
    logic signed [DATA_W-1:0] imm_reg, imm_next;
    logic [VAR_W-1:0]        vsel_reg, vsel_next;
    logic [ROUTINE_W-1:0]    tgt_reg, tgt_next;
    logic [ROUTINE_W-1:0]    start_reg, start_next;
    logic [ROUTINE_W-1:0]    cur_reg, cur_next;
    logic [LW-1:0]           pos_reg, pos_next;
    logic [DATA_W-1:0]       step_reg, step_next;
    logic                    dropped_reg, dropped_next;
    logic [DATA_W-1:0]       prod_reg, prod_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    o_fin_reg, o_fin_next;
    logic [DATA_W-1:0]       o_inst_reg, o_inst_next;
    logic [OUT_IDX_W-1:0]    o_idx_reg, o_idx_next;
    logic [ROUTINE_W-1:0]    o_rout_reg, o_rout_next;
    logic [DATA_W-1:0]       o_top_reg, o_top_next;
    logic [OUT_SIZE_W-1:0]   o_size_reg, o_size_next;
    logic                    o_ovf_reg, o_ovf_next;
    logic                    o_drop_reg, o_drop_next;

    // routine lengths: one read port, address chosen by state
    logic [LW-1:0]           len_reg [NUM_ROUTINES];
    logic [ROUTINE_W-1:0]    len_addr;
    logic                    len_ok;
    logic [LW-1:0]           len_rd;
    logic                    len_we;

    instr_t                  prog_mem [PDEP];
    instr_t                  prog_rd_reg;
    logic                    prog_we;
    logic                    prog_re;
    logic [PA_W-1:0]         prog_addr;
    instr_t                  prog_wdata;

    logic [DATA_W-1:0]       var_mem [NUM_VARS];
    logic                    var_valid_reg [NUM_VARS];
    logic [DATA_W-1:0]       var_rd_reg;
    logic                    var_ok_reg;
    logic                    var_we;
    logic                    var_re;
    logic [VAR_W-1:0]        var_addr;
    logic                    var_in_range;
    logic [DATA_W-1:0]       var_wdata;

    stk_cmd_t                stk_cmd;
    stk_stat_t               stk_st;
    logic [CW-1:0]           stk_count;
    logic [DATA_W-1:0]       alu_res;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign len_ok       = (32'(len_addr) < NUM_ROUTINES);
    assign len_rd       = len_ok ? len_reg[RW'(len_addr)] : '0;
    assign var_in_range = (32'(var_addr) < NUM_VARS);
    assign prod_next    = stk_st.second * stk_st.top;

    smstep_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .CW          (CW)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stk_cmd),
        .count (stk_count),
        .stat  (stk_st)
    );

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        rsel_next      = rsel_reg;
        opc_next       = opc_reg;
        imm_next       = imm_reg;
        vsel_next      = vsel_reg;
        tgt_next       = tgt_reg;
        start_next     = cfg_valid ? cfg_data : start_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        o_fin_next     = o_fin_reg;
        o_inst_next    = o_inst_reg;
        o_idx_next     = o_idx_reg;
        o_rout_next    = o_rout_reg;
        o_top_next     = o_top_reg;
        o_size_next    = o_size_reg;
        o_ovf_next     = o_ovf_reg;
        o_drop_next    = o_drop_reg;

        len_addr   = cur_reg;
        len_we     = 1'b0;
        prog_we    = 1'b0;
        prog_re    = 1'b0;
        prog_addr  = PA_W'(cur_reg) * RL_PA + PA_W'(pos_reg);
        prog_wdata = '{tgt: tgt_reg, var_idx: vsel_reg, imm: imm_reg, op: opc_reg};
        var_we     = 1'b0;
        var_re     = 1'b0;
        var_addr   = prog_rd_reg.var_idx;
        var_wdata  = stk_st.top;
        stk_cmd    = '{op: STK_NOP, value: '0};
        alu_res    = (prog_rd_reg.op == OP_SUB) ? stk_st.second - stk_st.top
                                                : stk_st.second + stk_st.top;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_next    = kind_t'(s_axis_tuser);
                    rsel_next    = s_axis_tdata[3:0];
                    opc_next     = opcode_t'(s_axis_tdata[6:4]);
                    imm_next     = s_axis_tdata[38:7];
                    vsel_next    = s_axis_tdata[42:39];
                    tgt_next     = s_axis_tdata[46:43];
                    dropped_next = 1'b0;
                    case (kind_t'(s_axis_tuser))
                        KIND_LOAD:   state_next = ST_LOAD;
                        KIND_STEP:   state_next = ST_FETCH;
                        KIND_ASSIGN: state_next = ST_ASSIGN;
                        default:     state_next = ST_RESTART;
                    endcase
                end
            end
            ST_LOAD:
            begin
                len_addr  = rsel_reg;
                prog_addr = PA_W'(rsel_reg) * RL_PA + PA_W'(len_rd);
                if (len_ok && (len_rd < LW'(ROUTINE_LEN)))
                begin
                    prog_we = 1'b1;
                    len_we  = 1'b1;
                end
                else
                begin
                    dropped_next = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_FETCH:
            begin
                if (pos_reg < len_rd)
                begin
                    prog_re    = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (prog_rd_reg.op)
                    OP_PUSH:
                    begin
                        stk_cmd   = '{op: STK_PUSH, value: prog_rd_reg.imm};
                        pos_next  = pos_reg + 1'b1;
                        step_next = step_reg + 1'b1;
                    end
                    OP_ADD, OP_SUB:
                    begin
                        stk_cmd   = '{op: STK_BINOP, value: alu_res};
                        pos_next  = pos_reg + 1'b1;
                        step_next = step_reg + 1'b1;
                    end
                    OP_MUL:
                    begin
                        state_next = ST_MUL_WB;
                    end
                    OP_WRITE:
                    begin
                        stk_cmd   = '{op: STK_POP, value: '0};
                        var_we    = var_in_range;
                        pos_next  = pos_reg + 1'b1;
                        step_next = step_reg + 1'b1;
                    end
                    OP_READ:
                    begin
                        var_re     = 1'b1;
                        state_next = ST_VAR_WB;
                    end
                    OP_JUMP:
                    begin
                        cur_next  = prog_rd_reg.tgt;
                        pos_next  = '0;
                        step_next = step_reg + 1'b1;
                    end
                    default:
                    begin
                        // jump if zero: the tested value is always popped
                        stk_cmd = '{op: STK_POP, value: '0};
                        if (stk_st.top == '0)
                        begin
                            cur_next = prog_rd_reg.tgt;
                            pos_next = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                        step_next = step_reg + 1'b1;
                    end
                endcase
            end
            ST_MUL_WB:
            begin
                stk_cmd    = '{op: STK_BINOP, value: prod_reg};
                pos_next   = pos_reg + 1'b1;
                step_next  = step_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_VAR_WB:
            begin
                stk_cmd    = '{op: STK_PUSH, value: var_ok_reg ? var_rd_reg : '0};
                pos_next   = pos_reg + 1'b1;
                step_next  = step_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_ASSIGN:
            begin
                var_addr   = vsel_reg;
                var_wdata  = imm_reg;
                var_we     = var_in_range;
                state_next = ST_DONE;
            end
            ST_RESTART:
            begin
                cur_next   = start_reg;
                pos_next   = '0;
                step_next  = '0;
                stk_cmd    = '{op: STK_CLEAR, value: '0};
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    o_fin_next     = !(pos_reg < len_rd);
                    o_inst_next    = step_reg;
                    o_idx_next     = OUT_IDX_W'(pos_reg);
                    o_rout_next    = cur_reg;
                    o_top_next     = stk_st.top;
                    o_size_next    = OUT_SIZE_W'(stk_count);
                    o_ovf_next     = stk_st.overflow;
                    o_drop_next    = dropped_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_LOAD;
            rsel_reg      <= '0;
            opc_reg       <= OP_PUSH;
            imm_reg       <= '0;
            vsel_reg      <= '0;
            tgt_reg       <= '0;
            start_reg     <= '0;
            cur_reg       <= '0;
            pos_reg       <= '0;
            step_reg      <= '0;
            dropped_reg   <= 1'b0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            o_fin_reg     <= 1'b0;
            o_inst_reg    <= '0;
            o_idx_reg     <= '0;
            o_rout_reg    <= '0;
            o_top_reg     <= '0;
            o_size_reg    <= '0;
            o_ovf_reg     <= 1'b0;
            o_drop_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            rsel_reg      <= rsel_next;
            opc_reg       <= opc_next;
            imm_reg       <= imm_next;
            vsel_reg      <= vsel_next;
            tgt_reg       <= tgt_next;
            start_reg     <= start_next;
            cur_reg       <= cur_next;
            pos_reg       <= pos_next;
            step_reg      <= step_next;
            dropped_reg   <= dropped_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
            o_fin_reg     <= o_fin_next;
            o_inst_reg    <= o_inst_next;
            o_idx_reg     <= o_idx_next;
            o_rout_reg    <= o_rout_next;
            o_top_reg     <= o_top_next;
            o_size_reg    <= o_size_next;
            o_ovf_reg     <= o_ovf_next;
            o_drop_reg    <= o_drop_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ROUTINES; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (len_we)
        begin
            len_reg[RW'(len_addr)] <= len_rd + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[prog_addr] <= prog_wdata;
        end
        if (prog_re)
        begin
            prog_rd_reg <= prog_mem[prog_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (var_we)
        begin
            var_mem[VIW'(var_addr)] <= var_wdata;
        end
        if (var_re)
        begin
            var_rd_reg <= var_mem[VIW'(var_addr)];
        end
    end

    // never-written variables read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_VARS; i++)
            begin
                var_valid_reg[i] <= 1'b0;
            end
            var_ok_reg <= 1'b0;
        end
        else
        begin
            if (var_we)
            begin
                var_valid_reg[VIW'(var_addr)] <= 1'b1;
            end
            if (var_re)
            begin
                var_ok_reg <= var_in_range && var_valid_reg[VIW'(var_addr)];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, o_drop_reg, o_ovf_reg, o_size_reg, o_top_reg,
                            o_rout_reg, o_idx_reg, o_inst_reg, o_fin_reg};

    `ASSERT_ALWAYS(a_stack_bound, clk, rst_n, stk_count <= CW'(STACK_DEPTH))
    `ASSERT_ALWAYS(a_pos_bound, clk, rst_n, pos_reg <= LW'(ROUTINE_LEN))
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_IMPLY(a_drop_on_load, clk, rst_n, dropped_reg, kind_reg == KIND_LOAD)

endmodule

### rtl/core/smstep_cell.sv
module smstep_cell (
    input  logic                           clk,
    input  smstep_pkg::cell_op_t           op,
    input  logic [smstep_pkg::DATA_W-1:0]  prev_val,
    input  logic [smstep_pkg::DATA_W-1:0]  next_val,
    output logic [smstep_pkg::DATA_W-1:0]  val
);
    import smstep_pkg::*;

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    always_comb
    begin
        case (op)
            CELL_PREV: val_next = prev_val;
            CELL_NEXT: val_next = next_val;
            default:   val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

### rtl/core/smstep_stack.sv
module smstep_stack #(
    parameter int STACK_DEPTH = smstep_pkg::DEF_STACK_DEPTH,
    parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smstep_pkg::stk_cmd_t  cmd,
    output logic [CW-1:0]         count,
    output smstep_pkg::stk_stat_t stat
);
    import smstep_pkg::*;

    logic [DATA_W-1:0] cell_val [STACK_DEPTH];
    cell_op_t          op_top;
    cell_op_t          op_rest;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              full;
    logic              empty;

    assign full  = (count_reg == CW'(STACK_DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        op_top     = CELL_HOLD;
        op_rest    = CELL_HOLD;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        case (cmd.op)
            STK_PUSH:
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    op_top     = CELL_PREV;
                    op_rest    = CELL_PREV;
                    count_next = count_reg + 1'b1;
                end
            end
            STK_POP:
            begin
                if (!empty)
                begin
                    op_top     = CELL_NEXT;
                    op_rest    = CELL_NEXT;
                    count_next = count_reg - 1'b1;
                end
            end
            STK_BINOP:
            begin
                // two pops and one push: top takes the result, the rest move up one
                op_top     = CELL_PREV;
                op_rest    = CELL_NEXT;
                count_next = (count_reg >= CW'(2)) ? count_reg - 1'b1 : CW'(1);
            end
            STK_CLEAR:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            default:
            begin
                op_top  = CELL_HOLD;
                op_rest = CELL_HOLD;
            end
        endcase
    end

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            smstep_cell u_cell (
                .clk      (clk),
                .op       (op_top),
                .prev_val (cmd.value),
                .next_val (cell_val[1]),
                .val      (cell_val[0])
            );
        end
        else if (i == STACK_DEPTH - 1)
        begin : g_tail
            smstep_cell u_cell (
                .clk      (clk),
                .op       (op_rest),
                .prev_val (cell_val[i-1]),
                .next_val ('0),
                .val      (cell_val[i])
            );
        end
        else
        begin : g_mid
            smstep_cell u_cell (
                .clk      (clk),
                .op       (op_rest),
                .prev_val (cell_val[i-1]),
                .next_val (cell_val[i+1]),
                .val      (cell_val[i])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // cells above the count hold stale data; empty pops read as zero
    assign stat.top      = empty ? '0 : cell_val[0];
    assign stat.second   = (count_reg >= CW'(2)) ? cell_val[1] : '0;
    assign stat.full     = full;
    assign stat.overflow = ovf_reg;
    assign count         = count_reg;

endmodule

### bench/stack_machine_step_tb.sv
module stack_machine_step_tb;
    import smstep_pkg::*;

    localparam int NR = DEF_NUM_ROUTINES;
    localparam int RLEN = DEF_ROUTINE_LEN;
    localparam int SD = DEF_STACK_DEPTH;
    localparam int NV = DEF_NUM_VARS;
    localparam int RANDOM_ITEMS = 1550;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;

    // s_axis_tdata layout, lowest field last
    typedef struct packed {
        logic                 zero;
        logic [ROUTINE_W-1:0] jmp_tgt;
        logic [VAR_W-1:0]     var_sel;
        logic [DATA_W-1:0]    imm;
        opcode_t              op;
        logic [ROUTINE_W-1:0] rtn_sel;
    } instr_word_t;

    typedef struct {
        kind_t       kind;
        instr_word_t word;
    } request_t;

    // m_axis_tdata layout, lowest field last
    typedef struct packed {
        logic [2:0]            zero;
        logic                  load_full;
        logic                  stk_ovf;
        logic [OUT_SIZE_W-1:0] stk_size;
        logic [DATA_W-1:0]     stk_top;
        logic [ROUTINE_W-1:0]  rtn_now;
        logic [OUT_IDX_W-1:0]  instr_idx;
        logic [DATA_W-1:0]     instant;
        logic                  finished;
    } machine_status_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [ROUTINE_W-1:0]   cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [KIND_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    stack_machine_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // machine state as the predictor sees it
    instr_word_t       prog_mem [NR][RLEN];
    int                code_len [NR];
    logic [DATA_W-1:0] vstack [SD];
    int                depth;
    logic [DATA_W-1:0] var_mem [NV];
    logic [ROUTINE_W-1:0] cur_rtn;
    logic [ROUTINE_W-1:0] start_rtn;
    int                pc;
    logic [DATA_W-1:0] step_cnt;
    logic              ovf_sticky;

    request_t          request_q[$];
    machine_status_t   status_q[$];
    request_t          cur_req;
    machine_status_t   mon_got;
    machine_status_t   mon_want;

    int queued_total = 0;
    int accepted_cnt = 0;
    int results_cnt = 0;
    int errors = 0;
    int cfg_writes = 0;
    int loads_dropped = 0;
    int overflow_results = 0;
    int send_idle = 8;
    int recv_idle = 72;
    int hold_at = 32'h7fff_ffff;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int cycle_cnt = 0;

    function automatic logic [DATA_W-1:0] take_top();
        if (depth == 0)
            return '0;
        depth--;
        return vstack[depth];
    endfunction

    function automatic void push_stack(logic [DATA_W-1:0] v);
        if (depth >= SD)
            ovf_sticky = 1'b1;
        else
        begin
            vstack[depth] = v;
            depth++;
        end
    endfunction

    function automatic void machine_apply(request_t r);
        instr_word_t       ins;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        machine_status_t   st;
        st = '0;
        case (r.kind)
            KIND_LOAD:
                if (code_len[r.word.rtn_sel] >= RLEN)
                    st.load_full = 1'b1;
                else
                begin
                    prog_mem[r.word.rtn_sel][code_len[r.word.rtn_sel]] = r.word;
                    code_len[r.word.rtn_sel]++;
                end
            KIND_STEP:
                if (pc < code_len[cur_rtn])
                begin
                    ins = prog_mem[cur_rtn][pc];
                    pc++;
                    case (ins.op)
                        OP_PUSH:  push_stack(ins.imm);
                        OP_ADD:
                        begin
                            a = take_top();
                            b = take_top();
                            push_stack(b + a);
                        end
                        OP_SUB:
                        begin
                            a = take_top();
                            b = take_top();
                            push_stack(b - a);
                        end
                        OP_MUL:
                        begin
                            a = take_top();
                            b = take_top();
                            push_stack(b * a);
                        end
                        OP_WRITE: var_mem[ins.var_sel] = take_top();
                        OP_READ:  push_stack(var_mem[ins.var_sel]);
                        OP_JUMP:
                        begin
                            cur_rtn = ins.jmp_tgt;
                            pc = 0;
                        end
                        OP_JUMPZ:
                            if (take_top() == '0)
                            begin
                                cur_rtn = ins.jmp_tgt;
                                pc = 0;
                            end
                    endcase
                    step_cnt++;
                end
            KIND_ASSIGN: var_mem[r.word.var_sel] = r.word.imm;
            KIND_RESTART:
            begin
                cur_rtn = start_rtn;
                pc = 0;
                depth = 0;
                step_cnt = '0;
                ovf_sticky = 1'b0;
            end
        endcase
        st.finished = (pc >= code_len[cur_rtn]);
        st.instant = step_cnt;
        st.instr_idx = OUT_IDX_W'(pc);
        st.rtn_now = cur_rtn;
        st.stk_top = (depth != 0) ? vstack[depth - 1] : '0;
        st.stk_size = OUT_SIZE_W'(depth);
        st.stk_ovf = ovf_sticky;
        if (st.load_full)
            loads_dropped++;
        if (st.stk_ovf)
            overflow_results++;
        status_q.insert(status_q.size(), st);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                machine_apply(cur_req);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    cur_req = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= cur_req.word;
                    s_axis_tuser <= cur_req.kind;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long output stall, once
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && accepted_cnt >= hold_at)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk)
        m_axis_tready <= rst_n && hold_left == 0 && $urandom_range(99) >= recv_idle;

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_cnt <= results_cnt + 1;
            mon_got = m_axis_tdata;
            if (status_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         m_axis_tdata);
                errors++;
            end
            else
            begin
                mon_want = status_q.pop_front();
                check_field("finished", DATA_W'(mon_want.finished),
                            DATA_W'(mon_got.finished));
                check_field("instant", mon_want.instant, mon_got.instant);
                check_field("instruction_index", DATA_W'(mon_want.instr_idx),
                            DATA_W'(mon_got.instr_idx));
                check_field("routine_now", DATA_W'(mon_want.rtn_now),
                            DATA_W'(mon_got.rtn_now));
                check_field("stack_top", mon_want.stk_top, mon_got.stk_top);
                check_field("stack_size", DATA_W'(mon_want.stk_size),
                            DATA_W'(mon_got.stk_size));
                check_field("stack_overflow", DATA_W'(mon_want.stk_ovf),
                            DATA_W'(mon_got.stk_ovf));
                check_field("load_full", DATA_W'(mon_want.load_full),
                            DATA_W'(mon_got.load_full));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                     cycle_cnt, status_q.size());
            $display("** stack_machine_step: FAILED **");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rand_imm();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hffff_ffff;
            3: return 32'h7fff_ffff;
            4: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_item(kind_t k, logic [ROUTINE_W-1:0] rs, opcode_t op,
                                       logic [DATA_W-1:0] imm, logic [VAR_W-1:0] vs,
                                       logic [ROUTINE_W-1:0] tg);
        request_t r;
        r.kind = k;
        r.word = '{zero: 1'b0, jmp_tgt: tg, var_sel: vs, imm: imm, op: op, rtn_sel: rs};
        request_q.insert(request_q.size(), r);
        queued_total++;
    endfunction

    function automatic void queue_random(kind_t k);
        queue_item(k, 4'($urandom_range(15)), opcode_t'($urandom_range(7)), rand_imm(),
                   4'($urandom_range(15)), 4'($urandom_range(15)));
    endfunction

    // routines 12..15 lean toward pushes so loops there run the stack full
    function automatic void add_load(logic [ROUTINE_W-1:0] rtn, logic [ROUTINE_W-1:0] home);
        opcode_t op;
        logic [ROUTINE_W-1:0] tg;
        if ($urandom_range(99) < ((rtn >= 12) ? 70 : 25))
            op = OP_PUSH;
        else
            op = opcode_t'($urandom_range(7));
        tg = $urandom_range(1) ? home : 4'($urandom_range(15));
        queue_item(KIND_LOAD, rtn, op, rand_imm(), 4'($urandom_range(15)), tg);
    endfunction

    task automatic drain();
        do
            @(posedge clk);
        while (accepted_cnt != queued_total || results_cnt != accepted_cnt);
    endtask

    task automatic set_start(logic [ROUTINE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_rtn = v;
        cfg_writes++;
    endtask

    initial
    begin
        int ep;
        int w;
        logic [ROUTINE_W-1:0] home;
        foreach (code_len[i])
            code_len[i] = 0;
        foreach (var_mem[i])
            var_mem[i] = '0;
        depth = 0;
        cur_rtn = '0;
        start_rtn = '0;
        pc = 0;
        step_cnt = '0;
        ovf_sticky = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_start(4'd0);

        // nothing loaded yet: finished from the start
        queue_item(KIND_STEP, 4'd0, OP_PUSH, 32'h0, 4'd0, 4'd0);
        queue_item(KIND_ASSIGN, 4'd0, OP_PUSH, 32'h8000_0000, 4'd3, 4'd0);
        queue_item(KIND_LOAD, 4'd0, OP_PUSH, 32'hffff_ffff, 4'd0, 4'd0);
        queue_item(KIND_LOAD, 4'd0, OP_PUSH, 32'h7fff_ffff, 4'd0, 4'd0);
        queue_item(KIND_LOAD, 4'd0, OP_MUL, 32'h0, 4'd0, 4'd0);
        queue_item(KIND_LOAD, 4'd0, OP_PUSH, 32'h8000_0000, 4'd0, 4'd0);
        queue_item(KIND_LOAD, 4'd0, OP_SUB, 32'h0, 4'd0, 4'd0);
        // second operand comes off an empty stack
        queue_item(KIND_LOAD, 4'd0, OP_ADD, 32'h0, 4'd0, 4'd0);
        queue_item(KIND_LOAD, 4'd0, OP_WRITE, 32'h0, 4'd15, 4'd0);
        queue_item(KIND_LOAD, 4'd0, OP_READ, 32'h0, 4'd15, 4'd0);
        queue_item(KIND_LOAD, 4'd0, OP_READ, 32'h0, 4'd3, 4'd0);
        queue_item(KIND_LOAD, 4'd0, OP_READ, 32'hffff_ffff, 4'd9, 4'd0);
        queue_item(KIND_LOAD, 4'd0, OP_JUMPZ, 32'h0, 4'd0, 4'd1);
        queue_item(KIND_LOAD, 4'd1, OP_JUMPZ, 32'h0, 4'd0, 4'd2);
        queue_item(KIND_RESTART, 4'd0, OP_PUSH, 32'h0, 4'd0, 4'd0);
        // last steps land past the end of routine 1
        repeat (13)
            queue_item(KIND_STEP, 4'd0, OP_PUSH, 32'h0, 4'd0, 4'd0);

        ep = 0;
        while (queued_total < RANDOM_ITEMS)
        begin
            drain();
            if (ep == 4)
            begin
                send_idle = 72;
                recv_idle = 8;
            end
            else if (ep == 8)
            begin
                send_idle = 0;
                recv_idle = 0;
                hold_at = queued_total + 40;
            end
            case (ep % 4)
                0: home = 4'd0;
                1: home = 4'd15;
                default: home = 4'($urandom_range(15));
            endcase
            set_start(home);

            repeat ($urandom_range(6, 14))
                add_load($urandom_range(3) == 0 ? 4'($urandom_range(15)) : home, home);
            if ($urandom_range(1))
                queue_item(KIND_LOAD, home, OP_JUMP, rand_imm(), 4'($urandom_range(15)), home);
            queue_random(KIND_RESTART);

            repeat ($urandom_range(80, 160))
            begin
                w = $urandom_range(99);
                if (w < 72)
                    queue_random(KIND_STEP);
                else if (w < 80)
                    add_load($urandom_range(1) ? home : 4'($urandom_range(15)), home);
                else if (w < 86)
                    queue_random(KIND_ASSIGN);
                else if (w < 88)
                    queue_random(KIND_RESTART);
                else
                    queue_random(kind_t'($urandom_range(3)));
            end
            ep++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (status_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, status_q.size());
            errors++;
        end
        $display("Ran %0d requests, %0d results checked, start routine set %0d times.",
                 accepted_cnt, results_cnt, cfg_writes);
        $display("%0d results carried the overflow flag, %0d loads hit a full routine.",
                 overflow_results, loads_dropped);
        if (errors == 0)
            $display("** stack_machine_step: PASSED **");
        else
            $display("** stack_machine_step: FAILED **");
        $finish;
    end

endmodule
